// ===== rtl/trc_pkg.sv =====
`timescale 1ns / 1ps
package trc_pkg;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic signed [15:0] right;
      logic signed [15:0] bottom;
   } clip_cfg_type;

   localparam logic [1:0] CSR_LEFT   = 2'd0;
   localparam logic [1:0] CSR_TOP    = 2'd1;
   localparam logic [1:0] CSR_RIGHT  = 2'd2;
   localparam logic [1:0] CSR_BOTTOM = 2'd3;

   localparam logic [1:0] LAST_CORNER = 2'd2;
   localparam logic [1:0] LAST_PASS   = 2'd3;
   localparam int NUM_FIELDS = 8;
   localparam logic [4:0] DIV_STEPS = 5'd17;

   typedef struct packed {
      logic        start;
      logic [15:0] num;
      logic [15:0] den;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [16:0] quot;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PASS_INIT,
      ST_PASS_VERT,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_MUL,
      ST_ADD,
      ST_LERP_PUT,
      ST_KEEP,
      ST_EMIT
   } back_state_type;

endpackage

// ===== rtl/trc_queue.sv =====
`timescale 1ns / 1ps
module trc_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             valid
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wp_ff, rp_ff;
   logic [1:0]       cnt_ff, cnt_in;

   assign full     = (cnt_ff == 2'd2);
   assign valid    = (cnt_ff != 2'd0);
   assign pop_data = mem_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 2'd1;
      else if (pop && !push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

endmodule

// ===== rtl/trc_front.sv =====
`timescale 1ns / 1ps
module trc_front #(
   parameter int AW = 16,
   localparam int VW = 32 + 6 * AW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [VW-1:0]         req_vertex,
   input  trc_pkg::clip_cfg_type cfg,
   output logic                  push,
   output logic [3*VW:0]         push_data,
   input  logic                  q_full
);
   import trc_pkg::*;

   logic [1:0]         corner_ff;
   logic [VW-1:0]      v0_ff, v1_ff;
   logic               accept, drop, fully_in;
   logic signed [15:0] min_x, max_x, min_y, max_y;

   function automatic logic signed [15:0] min3(input logic signed [15:0] a, b, c);
      logic signed [15:0] m;
      m = (b < a) ? b : a;
      m = (c < m) ? c : m;
      return m;
   endfunction

   function automatic logic signed [15:0] max3(input logic signed [15:0] a, b, c);
      logic signed [15:0] m;
      m = (b > a) ? b : a;
      m = (c > m) ? c : m;
      return m;
   endfunction

   assign req_tready = !((corner_ff == LAST_CORNER) && q_full);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      min_x = min3(signed'(v0_ff[15:0]), signed'(v1_ff[15:0]), signed'(req_vertex[15:0]));
      max_x = max3(signed'(v0_ff[15:0]), signed'(v1_ff[15:0]), signed'(req_vertex[15:0]));
      min_y = min3(signed'(v0_ff[31:16]), signed'(v1_ff[31:16]),
                   signed'(req_vertex[31:16]));
      max_y = max3(signed'(v0_ff[31:16]), signed'(v1_ff[31:16]),
                   signed'(req_vertex[31:16]));
      drop     = (max_x <= cfg.left) || (min_x >= cfg.right) ||
                 (max_y <= cfg.top) || (min_y >= cfg.bottom);
      fully_in = (min_x >= cfg.left) && (max_x <= cfg.right) &&
                 (min_y >= cfg.top) && (max_y <= cfg.bottom);
   end

   // drop rejected triangles here, the back end never sees them
   assign push      = accept && (corner_ff == LAST_CORNER) && !drop;
   assign push_data = {fully_in, req_vertex, v1_ff, v0_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff <= 2'd0;
      end else if (accept) begin
         corner_ff <= (corner_ff == LAST_CORNER) ? 2'd0 : corner_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && corner_ff == 2'd0) v0_ff <= req_vertex;
      if (accept && corner_ff == 2'd1) v1_ff <= req_vertex;
   end

endmodule

// ===== rtl/trc_divider.sv =====
`timescale 1ns / 1ps
module trc_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  trc_pkg::div_req_type div_req,
   output trc_pkg::div_rsp_type div_rsp
);
   import trc_pkg::*;

   logic [15:0] rem_ff, den_ff;
   logic [16:0] low_ff, quot_ff, r2, r2_sub;
   logic [4:0]  cnt_ff;
   logic        busy_ff, done_ff, ge;
   logic [32:0] dvd;

   // rounded dividend: num * 65536 + den / 2
   assign dvd    = {1'b0, div_req.num, 16'b0} + {18'b0, div_req.den[15:1]};
   assign r2     = {rem_ff, low_ff[16]};
   assign ge     = (r2 >= {1'b0, den_ff});
   assign r2_sub = r2 - {1'b0, den_ff};

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_STEPS;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff  <= dvd[32:17];
         low_ff  <= dvd[16:0];
         den_ff  <= div_req.den;
         quot_ff <= 17'd0;
      end else if (busy_ff) begin
         rem_ff  <= ge ? r2_sub[15:0] : r2[15:0];
         low_ff  <= {low_ff[15:0], 1'b0};
         quot_ff <= {quot_ff[15:0], ge};
      end
   end

endmodule

// ===== rtl/trc_back.sv =====
`timescale 1ns / 1ps
module trc_back #(
   parameter int MAXV = 7,
   parameter int AW = 16,
   localparam int VW = 32 + 6 * AW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  trc_pkg::clip_cfg_type cfg,
   input  logic                  q_valid,
   input  logic [3*VW:0]         q_data,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VW-1:0]         rsp_vertex,
   output logic [31:0]           rsp_number,
   output logic                  rsp_fan,
   output logic                  rsp_last
);
   import trc_pkg::*;

   localparam int IW = $clog2(MAXV);
   localparam int CW = $clog2(MAXV + 1);
   localparam int FW = ((AW > 16) ? AW : 16) + 1;
   localparam int PW = FW + 19;

   back_state_type state_ff, state_in;

   logic [VW-1:0]        buf_a_ff [MAXV];
   logic [VW-1:0]        buf_b_ff [MAXV];
   logic                 src_sel_ff;
   logic [CW-1:0]        n_ff, m_ff, m_in, idx_ff, rd_idx;
   logic [1:0]           pass_ff;
   logic [2:0]           fld_ff;
   logic [VW-1:0]        prev_ff, cur_ff, rd_vtx, lerp_vtx, wr_data;
   logic                 cur_in_ff;
   logic [16:0]          t_ff;
   logic signed [PW-1:0] prod_ff, prod, rnd;
   logic signed [FW-1:0] pf_ff;
   logic [FW-1:0]        res_ff [NUM_FIELDS];
   logic signed [FW-1:0] p_fld [NUM_FIELDS];
   logic signed [FW-1:0] q_fld [NUM_FIELDS];
   logic signed [FW:0]   diff;
   logic signed [17:0]   t_sx;
   logic [FW:0]          sum;
   logic [31:0]          number_ff;
   logic                 rsp_valid_ff, rsp_fan_ff, rsp_last_ff;
   logic [VW-1:0]        rsp_vertex_ff;
   logic [31:0]          rsp_number_ff;

   logic                 axis, keep_ge, room, cur_in_c, prev_in_c, edge_cross, last_vert;
   logic                 emit_ok, emit_load, wr_en, div_start, advance;
   logic signed [15:0]   bound, pc, qc;
   logic signed [16:0]   num_s, den_s;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   function automatic logic signed [15:0] coord_of(input logic [VW-1:0] v, input logic ax);
      return ax ? signed'(v[31:16]) : signed'(v[15:0]);
   endfunction

   trc_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // single read port into the current source buffer
   assign rd_idx = (state_ff == ST_PASS_INIT) ? n_ff - CW'(1) : idx_ff;
   assign rd_vtx = src_sel_ff ? buf_b_ff[rd_idx[IW-1:0]] : buf_a_ff[rd_idx[IW-1:0]];

   assign axis    = pass_ff[1];
   assign keep_ge = !pass_ff[0];

   always_comb begin
      case (pass_ff)
         2'd0:    bound = cfg.left;
         2'd1:    bound = cfg.right;
         2'd2:    bound = cfg.top;
         default: bound = cfg.bottom;
      endcase
   end

   assign cur_in_c   = keep_ge ? (coord_of(rd_vtx, axis) >= bound)
                               : (coord_of(rd_vtx, axis) <= bound);
   assign prev_in_c  = keep_ge ? (coord_of(prev_ff, axis) >= bound)
                               : (coord_of(prev_ff, axis) <= bound);
   assign room       = (m_ff < CW'(MAXV));
   assign edge_cross = (cur_in_c != prev_in_c) && room;
   assign last_vert  = (idx_ff + CW'(1)) == n_ff;
   assign emit_ok    = !rsp_valid_ff || rsp_ready;

   // crossing factor operands, oriented so the denominator is positive
   always_comb begin
      pc    = coord_of(prev_ff, axis);
      qc    = coord_of(cur_ff, axis);
      num_s = 17'(bound) - 17'(pc);
      den_s = 17'(qc) - 17'(pc);
      if (den_s < 0) begin
         den_s = -den_s;
         num_s = -num_s;
      end
      if (num_s < 0) num_s = 17'sd0;
      else if (num_s > den_s) num_s = den_s;
   end

   assign div_req.start = div_start;
   assign div_req.num   = num_s[15:0];
   assign div_req.den   = den_s[15:0];

   for (genvar g = 0; g < NUM_FIELDS; g++) begin : g_fld
      if (g < 2) begin : g_pos
         assign p_fld[g] = FW'(signed'(prev_ff[16*g +: 16]));
         assign q_fld[g] = FW'(signed'(cur_ff[16*g +: 16]));
         assign lerp_vtx[16*g +: 16] = res_ff[g][15:0];
      end else begin : g_attr
         assign p_fld[g] = FW'(prev_ff[32+(g-2)*AW +: AW]);
         assign q_fld[g] = FW'(cur_ff[32+(g-2)*AW +: AW]);
         assign lerp_vtx[32+(g-2)*AW +: AW] = res_ff[g][AW-1:0];
      end
   end

   assign diff = {q_fld[fld_ff][FW-1], q_fld[fld_ff]} - {p_fld[fld_ff][FW-1], p_fld[fld_ff]};
   assign t_sx = {1'b0, t_ff};
   assign prod = diff * t_sx;
   assign rnd  = (prod_ff + PW'(32768)) >>> 16;
   assign sum  = {pf_ff[FW-1], pf_ff} + rnd[FW:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (q_valid) state_in = q_data[3*VW] ? ST_EMIT : ST_PASS_INIT;
         ST_PASS_INIT: state_in = (n_ff == CW'(0)) ? ST_EMIT : ST_PASS_VERT;
         ST_PASS_VERT: begin
            if (edge_cross) state_in = ST_DIV_START;
            else if (last_vert) state_in = (pass_ff == LAST_PASS) ? ST_EMIT : ST_PASS_INIT;
         end
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT:  if (div_rsp.done) state_in = ST_MUL;
         ST_MUL:       state_in = ST_ADD;
         ST_ADD:       state_in = (fld_ff == 3'(NUM_FIELDS - 1)) ? ST_LERP_PUT : ST_MUL;
         ST_LERP_PUT:  state_in = ST_KEEP;
         ST_KEEP: begin
            if (!last_vert) state_in = ST_PASS_VERT;
            else state_in = (pass_ff == LAST_PASS) ? ST_EMIT : ST_PASS_INIT;
         end
         ST_EMIT: begin
            if (n_ff < CW'(3)) state_in = ST_IDLE;
            else if (emit_ok && last_vert) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // control decode
   always_comb begin
      q_pop     = 1'b0;
      div_start = 1'b0;
      wr_en     = 1'b0;
      wr_data   = rd_vtx;
      emit_load = 1'b0;
      advance   = 1'b0;
      unique case (state_ff)
         ST_IDLE:      q_pop = q_valid;
         ST_PASS_VERT: begin
            if (!edge_cross) begin
               advance = 1'b1;
               wr_en   = cur_in_c && room;
            end
         end
         ST_DIV_START: div_start = 1'b1;
         ST_LERP_PUT: begin
            wr_en   = 1'b1;
            wr_data = lerp_vtx;
         end
         ST_KEEP: begin
            advance = 1'b1;
            wr_en   = cur_in_ff && room;
            wr_data = cur_ff;
         end
         ST_EMIT:      emit_load = (n_ff >= CW'(3)) && emit_ok;
         default: ;
      endcase
   end

   assign m_in = m_ff + CW'(wr_en);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_sel_ff   <= 1'b0;
         n_ff         <= '0;
         m_ff         <= '0;
         idx_ff       <= '0;
         pass_ff      <= 2'd0;
         fld_ff       <= 3'd0;
         number_ff    <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_PASS_INIT) m_ff <= '0;
         else m_ff <= m_in;
         if (q_pop || (state_ff == ST_PASS_INIT) || (advance && last_vert)) idx_ff <= '0;
         else if (advance || emit_load) idx_ff <= idx_ff + CW'(1);
         if (q_pop) begin
            n_ff       <= CW'(3);
            src_sel_ff <= 1'b0;
            pass_ff    <= 2'd0;
         end else if (advance && last_vert) begin
            // swap buffers, the new polygon becomes the source
            src_sel_ff <= ~src_sel_ff;
            n_ff       <= m_in;
            pass_ff    <= pass_ff + 2'd1;
         end
         if (state_ff == ST_DIV_WAIT) fld_ff <= 3'd0;
         else if (state_ff == ST_ADD) fld_ff <= fld_ff + 3'd1;
         if (emit_load) number_ff <= number_ff + 32'd1;
         if (emit_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         buf_a_ff[0] <= q_data[VW-1:0];
         buf_a_ff[1] <= q_data[2*VW-1:VW];
         buf_a_ff[2] <= q_data[3*VW-1:2*VW];
      end
      if (wr_en) begin
         if (src_sel_ff) buf_a_ff[m_ff[IW-1:0]] <= wr_data;
         else buf_b_ff[m_ff[IW-1:0]] <= wr_data;
      end
      if (state_ff == ST_PASS_INIT) prev_ff <= rd_vtx;
      if (state_ff == ST_PASS_VERT) begin
         cur_ff    <= rd_vtx;
         cur_in_ff <= cur_in_c;
      end
      if (advance) prev_ff <= (state_ff == ST_KEEP) ? cur_ff : rd_vtx;
      if (state_ff == ST_DIV_WAIT && div_rsp.done) t_ff <= div_rsp.quot;
      if (state_ff == ST_MUL) begin
         prod_ff <= prod;
         pf_ff   <= p_fld[fld_ff];
      end
      if (state_ff == ST_ADD) res_ff[fld_ff] <= sum[FW-1:0];
      if (emit_load) begin
         rsp_vertex_ff <= rd_vtx;
         rsp_number_ff <= number_ff;
         rsp_fan_ff    <= (idx_ff == CW'(0));
         rsp_last_ff   <= last_vert;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_vertex = rsp_vertex_ff;
   assign rsp_number = rsp_number_ff;
   assign rsp_fan    = rsp_fan_ff;
   assign rsp_last   = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset) m_ff <= CW'(MAXV))
      else $error("polygon write index past buffer depth");
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_DIV_START) |=> div_rsp.busy)
      else $error("divider did not start");
   assert property (@(posedge clock) disable iff (reset)
                    (emit_load && last_vert) |=> (state_ff == ST_IDLE))
      else $error("sequencer kept going after last vertex");
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_MUL) |-> !div_rsp.busy)
      else $error("interpolation started before division finished");

endmodule

// ===== rtl/triangle_rect_clipper.sv =====
`timescale 1ns / 1ps
// Vertices are taken one per cycle (a third waits while the queue is full); every third one
// completes a triangle. A fully inside triangle is emitted one vertex per cycle while accepted.
// A clipped triangle takes up to 4 passes of a setup state and a vertex walk; each edge
// crossing adds a 17-step serial divider, then one shared multiplier over 8 fields.
// A two-entry triangle queue lets vertex intake continue while the sequencer works.
// Synchronous active-high reset clears control state and restores the clip rectangle.
module triangle_rect_clipper #(
   parameter int MAX_POLY_VERTS = 7,
   parameter int ATTR_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // pos_x, pos_y, red, green, blue, alpha, tex_u, tex_v
   input  logic [((32+6*ATTR_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // out_x, out_y, out_red, out_green, out_blue, out_alpha, out_u, out_v, vertex_number
   output logic [((64+6*ATTR_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // fan_start
   output logic rsp_tuser,
   output logic rsp_tlast,
   input  logic        csr_wen,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import trc_pkg::*;

   localparam int VW = 32 + 6 * ATTR_WIDTH;
   localparam int OW = ((64 + 6 * ATTR_WIDTH + 7) / 8) * 8;

   clip_cfg_type  cfg_ff;
   logic          push, q_full, q_pop, q_valid;
   logic [3*VW:0] push_data, q_data;
   logic [VW-1:0] rsp_vertex;
   logic [31:0]   rsp_number;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left   <= 16'sd0;
         cfg_ff.top    <= 16'sd0;
         cfg_ff.right  <= 16'sd32767;
         cfg_ff.bottom <= 16'sd32767;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_LEFT:   cfg_ff.left   <= csr_wdata;
            CSR_TOP:    cfg_ff.top    <= csr_wdata;
            CSR_RIGHT:  cfg_ff.right  <= csr_wdata;
            CSR_BOTTOM: cfg_ff.bottom <= csr_wdata;
            default: ;
         endcase
      end
   end

   trc_front #(.AW(ATTR_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_vertex (req_tdata[VW-1:0]),
      .cfg        (cfg_ff),
      .push       (push),
      .push_data  (push_data),
      .q_full     (q_full)
   );

   trc_queue #(.WIDTH(3 * VW + 1)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .valid     (q_valid)
   );

   trc_back #(.MAXV(MAX_POLY_VERTS), .AW(ATTR_WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_vertex (rsp_vertex),
      .rsp_number (rsp_number),
      .rsp_fan    (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = OW'({rsp_number, rsp_vertex});

endmodule
